// ===== hdl/sqt_pkg.sv =====
// Package: token kinds, scan modes, keyword table and character classes for the SQL tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package sqt_pkg;

  localparam int unsigned DefaultMaxQueryLen = 65536;
  localparam int unsigned KwCount = 40;
  localparam int unsigned WordBufDepth = 8;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [3:0] {
    TK_STAR = 4'd0, TK_COMMA = 4'd1, TK_DOT = 4'd2, TK_LPAREN = 4'd3,
    TK_RPAREN = 4'd4, TK_SEMI = 4'd5, TK_STRING = 4'd6, TK_NUMBER = 4'd7,
    TK_KEYWORD = 4'd8, TK_IDENT = 4'd9, TK_OP = 4'd10, TK_END = 4'd11
  } token_kind_t;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0, M_STR = 3'd1, M_ESC = 3'd2, M_NUM = 3'd3, M_WORD = 3'd4, M_OP = 3'd5
  } scan_mode_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] source_length;
    logic [5:0]  keyword_index;
    logic [7:0]  op_first;
    logic [7:0]  op_second;
    logic [15:0] text_length;
    logic        last_of_run;
  } token_t;

  // Bundle of up to three tokens that one byte causes.
  typedef struct packed {
    logic [1:0] count;
    token_t     t0;
    token_t     t1;
    token_t     t2;
  } token_group_t;

  typedef logic [7:0] word_t [WordBufDepth];

  function automatic logic [63:0] kw_entry(input logic [5:0] k);
    case (k)
      6'd0:  kw_entry = "select";   6'd1:  kw_entry = "from";
      6'd2:  kw_entry = "where";    6'd3:  kw_entry = "join";
      6'd4:  kw_entry = "on";       6'd5:  kw_entry = "inner";
      6'd6:  kw_entry = "left";     6'd7:  kw_entry = "right";
      6'd8:  kw_entry = "full";     6'd9:  kw_entry = "natural";
      6'd10: kw_entry = "anti";     6'd11: kw_entry = "outer";
      6'd12: kw_entry = "group";    6'd13: kw_entry = "by";
      6'd14: kw_entry = "order";    6'd15: kw_entry = "asc";
      6'd16: kw_entry = "desc";     6'd17: kw_entry = "limit";
      6'd18: kw_entry = "as";       6'd19: kw_entry = "and";
      6'd20: kw_entry = "having";   6'd21: kw_entry = "between";
      6'd22: kw_entry = "in";       6'd23: kw_entry = "sum";
      6'd24: kw_entry = "count";    6'd25: kw_entry = "avg";
      6'd26: kw_entry = "min";      6'd27: kw_entry = "max";
      6'd28: kw_entry = "or";       6'd29: kw_entry = "not";
      6'd30: kw_entry = "like";     6'd31: kw_entry = "any";
      6'd32: kw_entry = "all";      6'd33: kw_entry = "case";
      6'd34: kw_entry = "insert";   6'd35: kw_entry = "update";
      6'd36: kw_entry = "delete";   6'd37: kw_entry = "into";
      6'd38: kw_entry = "set";      6'd39: kw_entry = "values";
      default: kw_entry = '0;
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input logic [5:0] k);
    logic [63:0] e;
    logic [3:0]  n;
    e = kw_entry(k);
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (e[8*i +: 8] != 8'd0) n = n + 4'd1;
    end
    return n;
  endfunction

  // Character j of keyword k (string literal is right-aligned).
  function automatic logic [7:0] kw_char(input logic [5:0] k, input logic [2:0] j);
    logic [63:0] e;
    logic [3:0]  n;
    logic [3:0]  p;
    e = kw_entry(k);
    n = kw_len(k);
    p = n - 4'd1 - {1'b0, j};
    return e[8*p[2:0] +: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction
  function automatic logic is_word_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction
  function automatic logic is_op_char(input logic [7:0] c);
    return c == "=" || c == "<" || c == ">" || c == "!" || c == "~" || c == "+" ||
           c == "-" || c == "/" || c == "%" || c == "&" || c == "|" || c == "^";
  endfunction
  function automatic logic op_pairs(input logic [7:0] a, input logic [7:0] b);
    if (a == "<") return b == "<" || b == "=";
    if (a == ">") return b == ">" || b == "=";
    return b == "=" || b == ">" || b == "<" || b == "|";
  endfunction
  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sqt_stream_if.sv =====
// Valid/ready stream interface carrying one item of a given payload type.
`timescale 1ns / 1ps
`default_nettype none
interface sqt_stream_if #(parameter type payload_t = logic [8:0]);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/sqt_scanner.sv =====
// Front end: scan state machine turning each byte into a group of up to three tokens.
`timescale 1ns / 1ps
`default_nettype none
module sqt_scanner #(
  parameter int unsigned MAX_QUERY_LEN = sqt_pkg::DefaultMaxQueryLen
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic [7:0]           byte_in,
  input  wire logic                 final_byte,
  output sqt_pkg::token_group_t     group
);
  import sqt_pkg::*;

  localparam logic [15:0] PosLimit =
    (MAX_QUERY_LEN - 1 < 65535) ? 16'(MAX_QUERY_LEN - 1) : 16'hFFFF;

  scan_mode_t  mode, mode_next;
  logic [7:0]  quote_char, quote_char_next;
  logic [15:0] byte_position, byte_position_next;
  logic [15:0] token_start, token_start_next;
  logic [15:0] unescaped_count, unescaped_count_next;
  logic [15:0] word_length, word_length_next;
  logic [7:0]  pending_op_char, pending_op_char_next;
  logic [7:0]  word_buffer [WordBufDepth];
  logic        wb_we;
  logic [2:0]  wb_addr;
  logic [7:0]  wb_data;

  token_t      toks [3];
  logic [1:0]  n;
  logic [5:0]  kw_idx;
  logic        kw_hit;

  // Parallel keyword match against the current buffered word.
  always_comb begin
    logic eq;
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int k = KwCount - 1; k >= 0; k--) begin
      eq = (word_length <= 16'd7) && ({12'd0, kw_len(6'(k))} == word_length);
      for (int j = 0; j < 7; j++) begin
        if (16'(j) < word_length && kw_char(6'(k), 3'(j)) != word_buffer[j]) eq = 1'b0;
      end
      if (eq) begin
        kw_hit = 1'b1;
        kw_idx = 6'(k);
      end
    end
  end

  // Match for a word that grows by this byte and is closed by the final byte.
  logic [7:0]  wnew [WordBufDepth];
  logic [15:0] wlen_grown;
  logic [5:0]  fkw_idx;
  logic        fkw_hit;
  always_comb begin
    logic eq;
    for (int j = 0; j < WordBufDepth; j++) wnew[j] = word_buffer[j];
    if (word_length < 16'(WordBufDepth)) wnew[word_length[2:0]] = to_lower(byte_in);
    wlen_grown = sat_inc(word_length);
    fkw_hit = 1'b0;
    fkw_idx = '0;
    for (int k = KwCount - 1; k >= 0; k--) begin
      eq = (wlen_grown <= 16'd7) && ({12'd0, kw_len(6'(k))} == wlen_grown);
      for (int j = 0; j < 7; j++) begin
        if (16'(j) < wlen_grown && kw_char(6'(k), 3'(j)) != wnew[j]) eq = 1'b0;
      end
      if (eq) begin
        fkw_hit = 1'b1;
        fkw_idx = 6'(k);
      end
    end
  end

  function automatic token_t mk(input token_kind_t k, input logic [15:0] s,
                                input logic [15:0] sl, input logic [5:0] kw,
                                input logic [7:0] o1, input logic [7:0] o2,
                                input logic [15:0] tl);
    token_t t;
    t.token_kind = k;
    t.start_offset = s;
    t.source_length = sl;
    t.keyword_index = kw;
    t.op_first = o1;
    t.op_second = o2;
    t.text_length = tl;
    t.last_of_run = 1'b0;
    return t;
  endfunction

  always_comb begin
    logic        restart;
    logic [15:0] pos;
    logic [15:0] nxt;
    logic [15:0] span;
    scan_mode_t  mcur;
    logic [15:0] ucnt;
    pos = byte_position;
    mode_next = mode;
    quote_char_next = quote_char;
    byte_position_next = byte_position;
    token_start_next = token_start;
    unescaped_count_next = unescaped_count;
    word_length_next = word_length;
    pending_op_char_next = pending_op_char;
    wb_we = 1'b0;
    wb_addr = '0;
    wb_data = to_lower(byte_in);
    n = '0;
    for (int i = 0; i < 3; i++) toks[i] = '0;
    restart = 1'b0;
    case (mode)
      M_STR: begin
        if (byte_in == quote_char) begin
          toks[n] = mk(TK_STRING, token_start, sat_inc(pos) - token_start, '0, '0, '0,
                       unescaped_count);
          n = n + 2'd1;
          mode_next = M_IDLE;
        end else if (byte_in == "\\") begin
          mode_next = M_ESC;
        end else begin
          unescaped_count_next = sat_inc(unescaped_count);
        end
      end
      M_ESC: begin
        unescaped_count_next = sat_inc(unescaped_count);
        mode_next = M_STR;
      end
      M_NUM: begin
        if (!(is_digit(byte_in) || byte_in == ".")) begin
          toks[n] = mk(TK_NUMBER, token_start, pos - token_start, '0, '0, '0,
                       pos - token_start);
          n = n + 2'd1;
          mode_next = M_IDLE;
          restart = 1'b1;
        end
      end
      M_WORD: begin
        if (is_word_char(byte_in)) begin
          if (word_length < 16'(WordBufDepth)) begin
            wb_we = 1'b1;
            wb_addr = word_length[2:0];
          end
          word_length_next = sat_inc(word_length);
        end else begin
          toks[n] = kw_hit ? mk(TK_KEYWORD, token_start, pos - token_start, kw_idx, '0, '0,
                                word_length)
                           : mk(TK_IDENT, token_start, pos - token_start, '0, '0, '0,
                                word_length);
          n = n + 2'd1;
          mode_next = M_IDLE;
          restart = 1'b1;
        end
      end
      M_OP: begin
        mode_next = M_IDLE;
        if (op_pairs(pending_op_char, byte_in)) begin
          toks[n] = mk(TK_OP, token_start, 16'd2, '0, pending_op_char, byte_in, 16'd2);
          n = n + 2'd1;
        end else begin
          toks[n] = mk(TK_OP, token_start, 16'd1, '0, pending_op_char, '0, 16'd1);
          n = n + 2'd1;
          restart = 1'b1;
        end
      end
      default: begin
        mode_next = M_IDLE;
        restart = 1'b1;
      end
    endcase
    if (restart && !is_space(byte_in)) begin
      case (byte_in)
        "*": begin toks[n] = mk(TK_STAR, pos, 16'd1, '0, '0, '0, 16'd1); n = n + 2'd1; end
        ",": begin toks[n] = mk(TK_COMMA, pos, 16'd1, '0, '0, '0, 16'd1); n = n + 2'd1; end
        ".": begin toks[n] = mk(TK_DOT, pos, 16'd1, '0, '0, '0, 16'd1); n = n + 2'd1; end
        "(": begin toks[n] = mk(TK_LPAREN, pos, 16'd1, '0, '0, '0, 16'd1); n = n + 2'd1; end
        ")": begin toks[n] = mk(TK_RPAREN, pos, 16'd1, '0, '0, '0, 16'd1); n = n + 2'd1; end
        ";": begin toks[n] = mk(TK_SEMI, pos, 16'd1, '0, '0, '0, 16'd1); n = n + 2'd1; end
        default: begin
          token_start_next = pos;
          if (byte_in == "'" || byte_in == "\"") begin
            mode_next = M_STR;
            quote_char_next = byte_in;
            unescaped_count_next = '0;
          end else if (is_digit(byte_in)) begin
            mode_next = M_NUM;
          end else if (is_alpha(byte_in) || byte_in == "_") begin
            mode_next = M_WORD;
            wb_we = 1'b1;
            wb_addr = '0;
            word_length_next = 16'd1;
          end else if (is_op_char(byte_in)) begin
            mode_next = M_OP;
            pending_op_char_next = byte_in;
          end else begin
            toks[n] = mk(TK_IDENT, pos, 16'd1, '0, '0, '0, 16'd1);
            n = n + 2'd1;
          end
        end
      endcase
    end
    if (final_byte) begin
      mcur = mode_next;
      ucnt = unescaped_count_next;
      nxt = (byte_position < PosLimit) ? byte_position + 16'd1 : PosLimit;
      span = (nxt >= token_start_next) ? nxt - token_start_next : 16'd0;
      case (mcur)
        M_ESC: begin
          toks[n] = mk(TK_STRING, token_start_next, span, '0, '0, '0, sat_inc(ucnt));
          n = n + 2'd1;
        end
        M_STR: begin
          toks[n] = mk(TK_STRING, token_start_next, span, '0, '0, '0, ucnt);
          n = n + 2'd1;
        end
        M_NUM: begin
          toks[n] = mk(TK_NUMBER, token_start_next, span, '0, '0, '0, span);
          n = n + 2'd1;
        end
        M_WORD: begin
          // a word opened by this byte has one character and is never a keyword
          if (mode == M_WORD && fkw_hit) begin
            toks[n] = mk(TK_KEYWORD, token_start_next, span, fkw_idx, '0, '0,
                         word_length_next);
          end else begin
            toks[n] = mk(TK_IDENT, token_start_next, span, '0, '0, '0, word_length_next);
          end
          n = n + 2'd1;
        end
        M_OP: begin
          toks[n] = mk(TK_OP, token_start_next, 16'd1, '0, pending_op_char_next, '0, 16'd1);
          n = n + 2'd1;
        end
        default: ;
      endcase
      toks[n] = mk(TK_END, nxt, '0, '0, '0, '0, '0);
      n = n + 2'd1;
      mode_next = M_IDLE;
      quote_char_next = '0;
      byte_position_next = '0;
      token_start_next = '0;
      unescaped_count_next = '0;
      word_length_next = '0;
      pending_op_char_next = '0;
    end else if (byte_position < PosLimit) begin
      byte_position_next = byte_position + 16'd1;
    end
  end

  always_comb begin
    token_t t [3];
    for (int i = 0; i < 3; i++) begin
      t[i] = toks[i];
      if (2'(i) == n - 2'd1) t[i].last_of_run = 1'b1;
    end
    group.count = n;
    group.t0 = t[0];
    group.t1 = t[1];
    group.t2 = t[2];
  end

  always_ff @(posedge clk) begin
    if (step && wb_we) word_buffer[wb_addr] <= wb_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      quote_char <= '0;
      byte_position <= '0;
      token_start <= '0;
      unescaped_count <= '0;
      word_length <= '0;
      pending_op_char <= '0;
    end else if (step) begin
      mode <= mode_next;
      quote_char <= quote_char_next;
      byte_position <= byte_position_next;
      token_start <= token_start_next;
      unescaped_count <= unescaped_count_next;
      word_length <= word_length_next;
      pending_op_char <= pending_op_char_next;
    end
  end

  a_pos_limit: assert property (@(posedge clk) disable iff (rst) byte_position <= PosLimit)
    else $error("position beyond limit");
  a_final_end: assert property (@(posedge clk) disable iff (rst)
    step && final_byte |-> group.count != 2'd0) else $error("final byte gave no end token");
  a_final_reset: assert property (@(posedge clk) disable iff (rst)
    step && final_byte |=> byte_position == 16'd0 && mode == M_IDLE)
    else $error("state not cleared after final byte");
endmodule
`default_nettype wire

// ===== hdl/sqt_group_queue.sv =====
// Short queue of token groups between the scanner and the output serialiser.
`timescale 1ns / 1ps
`default_nettype none
module sqt_group_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire sqt_pkg::token_group_t push_data,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      empty,
  output sqt_pkg::token_group_t     head
);
  import sqt_pkg::*;

  localparam int unsigned Aw = $clog2(QueueDepth);

  token_group_t mem [QueueDepth];
  logic [Aw-1:0] wr_ptr, rd_ptr;
  logic [Aw:0]   fill;

  assign full = fill == (Aw+1)'(QueueDepth);
  assign empty = fill == '0;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue underflow");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> fill == $past(fill) + 1'b1) else $error("fill count slip");
endmodule
`default_nettype wire

// ===== hdl/sqt_emitter.sv =====
// Back end: sends each queued group's tokens through an output register, one per cycle while ready.
`timescale 1ns / 1ps
`default_nettype none
module sqt_emitter (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  empty,
  input  wire sqt_pkg::token_group_t head,
  output logic                       pop,
  sqt_stream_if.source               tok_out
);
  import sqt_pkg::*;

  logic [1:0] sel;
  logic       load;
  token_t     cur;

  always_comb begin
    case (sel)
      2'd0: cur = head.t0;
      2'd1: cur = head.t1;
      default: cur = head.t2;
    endcase
  end

  assign load = !empty && head.count != 2'd0 && (!tok_out.valid || tok_out.ready);
  assign pop = !empty && (head.count == 2'd0 || (load && sel == head.count - 2'd1));

  always_ff @(posedge clk) begin
    if (load) tok_out.data <= cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
      sel <= '0;
    end else begin
      if (load) tok_out.valid <= 1'b1;
      else if (tok_out.ready) tok_out.valid <= 1'b0;
      if (pop) sel <= '0;
      else if (load) sel <= sel + 2'd1;
    end
  end

  a_sel_range: assert property (@(posedge clk) disable iff (rst) !empty |-> sel < 2'd3)
    else $error("token select out of range");
  a_last_pop: assert property (@(posedge clk) disable iff (rst)
    load && cur.last_of_run |-> pop) else $error("group left after last token");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    tok_out.valid && !tok_out.ready |=> tok_out.valid) else $error("output dropped");
endmodule
`default_nettype wire

// ===== hdl/sql_query_tokenizer.sv =====
// Top level of the streaming SQL tokenizer.
`timescale 1ns / 1ps
`default_nettype none
// Takes one query byte per cycle and returns token descriptors, one per cycle on the output
// while it is ready. A byte may close a token, open a one-byte token and, when final, add an
// end token, so it yields up to three items; the group is held in a four-entry queue and the
// emitter drains it at one token per cycle while the output is ready. Input rate is one byte
// per cycle while output keeps pace, and the back end sets the sustained rate on token-dense
// text. Keywords are matched against all 40 entries in parallel in the cycle the word closes.
module sql_query_tokenizer #(
  parameter int unsigned MAX_QUERY_LEN = sqt_pkg::DefaultMaxQueryLen
) (
  input wire logic     clk,
  input wire logic     rst,
  sqt_stream_if.sink   byte_stream,
  sqt_stream_if.source token_stream
);
  import sqt_pkg::*;

  token_group_t group, head;
  logic         full, empty, pop, step;

  assign byte_stream.ready = !full;
  assign step = byte_stream.valid && byte_stream.ready;

  sqt_scanner #(.MAX_QUERY_LEN(MAX_QUERY_LEN)) u_scanner (
    .clk(clk), .rst(rst), .step(step),
    .byte_in(byte_stream.data[8:1]), .final_byte(byte_stream.data[0]), .group(group)
  );

  sqt_group_queue u_queue (
    .clk(clk), .rst(rst), .push(step), .push_data(group), .full(full),
    .pop(pop), .empty(empty), .head(head)
  );

  sqt_emitter u_emitter (
    .clk(clk), .rst(rst), .empty(empty), .head(head), .pop(pop), .tok_out(token_stream)
  );
endmodule
`default_nettype wire
